[design/chtbl_pkg.sv]
// ----------------------------------------------------------------------------
// chtbl_pkg
// shared widths, request codes and types of the chained hash table
// ----------------------------------------------------------------------------
package chtbl_pkg;

    localparam int KEY_W       = 31;
    localparam int REQ_W       = 2;
    localparam int POS_W       = 9;
    localparam int CFG_W       = 7;
    localparam int DEF_BUCKETS = 64;
    localparam int DEF_NODES   = 256;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
    } t_mod_req;

endpackage

[design/chained_hash_table_core.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_core
// hash table with separate chaining over a bounded node pool
// ----------------------------------------------------------------------------
// One request at a time: insert, search or delete of a 31-bit key. The bucket
// is the key modulo the configured bucket count, found by a bit-serial
// remainder unit. An insert then reads the bucket head and links in a
// never-used node, or first reads and pops the free list head; a search or
// delete reads the bucket head, then for each chain node visited reads node
// memory and then compares, and a delete that hits also pushes the freed node
// on the free list. An unknown request goes straight to its empty result.
// After reset the block clears its bucket head memory, one entry a cycle, and
// holds o_stall high meanwhile; bucket count writes are taken at any time. A
// result sits in an output register, so the next request is accepted while
// the last result still waits; a finished request waits only while that
// register is still full and stalled.
// ----------------------------------------------------------------------------
module chained_hash_table_core import chtbl_pkg::*; #(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int NODES   = DEF_NODES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [KEY_W-1:0] i_key,
    // result channel
    output logic             o_valid,
    input  logic             i_stall,
    output logic [POS_W-1:0] o_position,
    output logic             o_status,
    // bucket count register
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // node index with one extra code for null (value NODES)
    localparam int NW  = $clog2(NODES + 1);
    localparam int AW  = $clog2(NODES);
    localparam int BAW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int BW  = $clog2(BUCKETS + 1);
    localparam logic [NW-1:0] NIL = NW'(NODES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MOD, S_HEAD_RD, S_HEAD, S_ALLOC_RD, S_ALLOC,
        S_WALK_RD, S_WALK, S_UNLINK, S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_bucket_count;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [BAW-1:0]    r_bucket, n_bucket;
    logic [BAW-1:0]    r_clr, n_clr;
    logic [NW-1:0]     r_free, n_free;
    logic [NW-1:0]     r_fresh, n_fresh;
    logic [NW-1:0]     r_p, n_p;
    logic [NW-1:0]     r_prev, n_prev;
    logic [NW-1:0]     r_steps, n_steps;
    logic [POS_W-1:0]  r_res_pos, n_res_pos;
    logic              r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic              r_out_status, n_out_status;

    // memories
    logic [NW-1:0]     r_heads [BUCKETS];
    logic [KEY_W-1:0]  r_keys  [NODES];
    logic [NW-1:0]     r_links [NODES];
    logic [NW-1:0]     r_hd_q;
    logic [KEY_W-1:0]  r_key_q;
    logic [NW-1:0]     r_lk_q;

    logic              w_hd_we;
    logic [BAW-1:0]    w_hd_wa;
    logic [NW-1:0]     w_hd_wd;
    logic              w_key_we;
    logic              w_lk_we;
    logic [AW-1:0]     w_key_wa;
    logic [AW-1:0]     w_lk_wa;
    logic [NW-1:0]     w_lk_wd;
    logic [AW-1:0]     w_nd_ra;

    logic              w_accept;
    logic [BW-1:0]     w_modulus;
    t_mod_req          w_mod_req;
    logic              w_mod_done;
    logic [BW-1:0]     w_mod_rem;
    logic [31:0]       w_pos32;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_pos32  = 32'(r_steps) + 32'd1;

    // saturate the configured count into 1..BUCKETS
    always_comb begin
        if (r_bucket_count == '0) begin
            w_modulus = BW'(1);
        end else if (32'(r_bucket_count) > 32'(BUCKETS)) begin
            w_modulus = BW'(BUCKETS);
        end else begin
            w_modulus = BW'(r_bucket_count);
        end
    end

    assign w_mod_req.start    = w_accept && (i_req_type == REQ_INSERT ||
                                i_req_type == REQ_SEARCH || i_req_type == REQ_DELETE);
    assign w_mod_req.dividend = i_key;

    chtbl_mod #(.BW(BW)) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mod_req),
        .i_modulus (w_modulus),
        .o_done    (w_mod_done),
        .o_rem     (w_mod_rem)
    );

    // node memory read port: free list head while allocating, else walk pointer
    assign w_nd_ra = (r_state == S_ALLOC_RD) ? r_free[AW-1:0] : r_p[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_key        = r_key;
        n_bucket     = r_bucket;
        n_clr        = r_clr;
        n_free       = r_free;
        n_fresh      = r_fresh;
        n_p          = r_p;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_res_pos    = r_res_pos;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_pos    = r_out_pos;
        n_out_status = r_out_status;
        w_hd_we      = 1'b0;
        w_hd_wa      = r_bucket;
        w_hd_wd      = NIL;
        w_key_we     = 1'b0;
        w_key_wa     = r_fresh[AW-1:0];
        w_lk_we      = 1'b0;
        w_lk_wa      = r_p[AW-1:0];
        w_lk_wd      = r_hd_q;

        // result taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // sweep all bucket heads to null
                w_hd_we = 1'b1;
                w_hd_wa = r_clr;
                w_hd_wd = NIL;
                n_clr   = r_clr + 1'b1;
                if (r_clr == BAW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_req        = i_req_type;
                    n_key        = i_key;
                    n_res_pos    = '0;
                    n_res_status = 1'b0;
                    // unknown request: no state change, empty result
                    n_state      = w_mod_req.start ? S_MOD : S_FIN;
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_bucket = w_mod_rem[BAW-1:0];
                    n_state  = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                n_state = S_HEAD;
            end
            S_HEAD: begin
                if (r_req == REQ_INSERT) begin
                    if (r_free < NW'(NODES)) begin
                        n_state = S_ALLOC_RD;
                    end else if (r_fresh < NW'(NODES)) begin
                        // take the next never-used node
                        w_key_we = 1'b1;
                        w_key_wa = r_fresh[AW-1:0];
                        w_lk_we  = 1'b1;
                        w_lk_wa  = r_fresh[AW-1:0];
                        w_lk_wd  = r_hd_q;
                        w_hd_we  = 1'b1;
                        w_hd_wd  = r_fresh;
                        n_fresh  = r_fresh + 1'b1;
                        n_state  = S_FIN;
                    end else begin
                        // pool full, drop
                        n_res_status = 1'b1;
                        n_state      = S_FIN;
                    end
                end else begin
                    n_p     = r_hd_q;
                    n_prev  = NIL;
                    n_steps = '0;
                    n_state = S_WALK_RD;
                end
            end
            S_ALLOC_RD: begin
                n_state = S_ALLOC;
            end
            S_ALLOC: begin
                // pop the free list head
                w_key_we = 1'b1;
                w_key_wa = r_free[AW-1:0];
                w_lk_we  = 1'b1;
                w_lk_wa  = r_free[AW-1:0];
                w_lk_wd  = r_hd_q;
                w_hd_we  = 1'b1;
                w_hd_wd  = r_free;
                n_free   = r_lk_q;
                n_state  = S_FIN;
            end
            S_WALK_RD: begin
                if (r_p < NW'(NODES) && r_steps < NW'(NODES)) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WALK: begin
                if (r_key_q == r_key) begin
                    n_res_pos = w_pos32[POS_W-1:0];
                    if (r_req == REQ_DELETE) begin
                        // bypass the matched node
                        if (r_prev < NW'(NODES)) begin
                            w_lk_we = 1'b1;
                            w_lk_wa = r_prev[AW-1:0];
                            w_lk_wd = r_lk_q;
                        end else begin
                            w_hd_we = 1'b1;
                            w_hd_wd = r_lk_q;
                        end
                        n_state = S_UNLINK;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_prev  = r_p;
                    n_p     = r_lk_q;
                    n_steps = r_steps + 1'b1;
                    n_state = S_WALK_RD;
                end
            end
            S_UNLINK: begin
                // push the freed node on the free list
                w_lk_we = 1'b1;
                w_lk_wa = r_p[AW-1:0];
                w_lk_wd = r_free;
                n_free  = r_p;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_pos    = r_res_pos;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_free         <= NIL;
            r_fresh        <= '0;
            r_out_valid    <= 1'b0;
            r_bucket_count <= CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free      <= n_free;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_data;
            end
        end
        r_req        <= n_req;
        r_key        <= n_key;
        r_bucket     <= n_bucket;
        r_p          <= n_p;
        r_prev       <= n_prev;
        r_steps      <= n_steps;
        r_res_pos    <= n_res_pos;
        r_res_status <= n_res_status;
        r_out_pos    <= n_out_pos;
        r_out_status <= n_out_status;
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (w_hd_we) begin
            r_heads[w_hd_wa] <= w_hd_wd;
        end
        r_hd_q <= r_heads[r_bucket];
    end

    // node key memory
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_keys[w_key_wa] <= r_key;
        end
        r_key_q <= r_keys[w_nd_ra];
    end

    // node link memory
    always_ff @(posedge i_clk) begin
        if (w_lk_we) begin
            r_links[w_lk_wa] <= w_lk_wd;
        end
        r_lk_q <= r_links[w_nd_ra];
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_out_pos;
    assign o_status   = r_out_status;

endmodule

[design/chtbl_mod.sv]
// ----------------------------------------------------------------------------
// chtbl_mod
// bit-serial remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module chtbl_mod import chtbl_pkg::*; #(
    parameter int BW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mod_req      i_req,
    input  logic [BW-1:0] i_modulus,
    output logic          o_done,
    output logic [BW-1:0] o_rem
);

    localparam int CW = $clog2(KEY_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [BW-1:0]    r_rem, n_rem;
    logic [BW-1:0]    r_m, n_m;
    logic [KEY_W-1:0] r_div, n_div;
    logic [BW:0]      w_sh;

    assign w_sh = {r_rem, r_div[KEY_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_m    = r_m;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(KEY_W - 1);
            n_rem  = '0;
            n_m    = i_modulus;
            n_div  = i_req.dividend;
        end else if (r_busy) begin
            // restoring step: shift in next bit, subtract if it fits
            if (w_sh >= {1'b0, r_m}) begin
                n_rem = BW'(w_sh - {1'b0, r_m});
            end else begin
                n_rem = w_sh[BW-1:0];
            end
            n_div = {r_div[KEY_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_m   <= n_m;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[design/chtbl_checker.sv]
// ----------------------------------------------------------------------------
// chtbl_checker
// port-level checks of the chained hash table, bound to the top level
// ----------------------------------------------------------------------------
module chtbl_checker import chtbl_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic [REQ_W-1:0] i_req_type,
    input logic [KEY_W-1:0] i_key,
    input logic             o_valid,
    input logic             i_stall,
    input logic [POS_W-1:0] o_position,
    input logic             o_status,
    input logic             i_cfg_we,
    input logic [CFG_W-1:0] i_cfg_data
);

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_position) && $stable(o_status))
        else $error("stalled result changed");

    // a dropped insert never reports a position
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_position == '0)
        else $error("dropped insert with position");

    // a request keeps the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request not held busy");

    // reset empties the result side and starts the clearing sweep
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("reset state wrong");

endmodule

bind chained_hash_table_core chtbl_checker u_chtbl_checker (.*);

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// randomized request test of the chained hash table core
// ----------------------------------------------------------------------------
// Requests are queued by a stimulus process and sent by a clocked driver. A
// clocked monitor takes each result and compares it with a result predicted
// from a shadow copy of the bucket chains, the free list and the pool. The
// bucket count is changed only while the table is idle. Random phases vary the
// idle pattern of the sender and the stall pattern of the receiver.
// ----------------------------------------------------------------------------
module tb;
    import chtbl_pkg::*;

    localparam int NBKT = DEF_BUCKETS;
    localparam int NND  = DEF_NODES;
    localparam int NULL_LINK = NND;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [KEY_W-1:0] key;
    } t_request;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             status;
    } t_outcome;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [REQ_W-1:0] i_req_type;
    logic [KEY_W-1:0] i_key;
    logic             o_valid;
    logic             i_stall;
    logic [POS_W-1:0] o_position;
    logic             o_status;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    // shadow table state
    int unsigned       sh_count;
    int unsigned       sh_heads [NBKT];
    logic [KEY_W-1:0]  sh_keys  [NND];
    int unsigned       sh_links [NND];
    int unsigned       sh_free;
    int unsigned       sh_fresh;

    t_request  pending_reqs [$];
    t_outcome  expected_outcomes [$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        error_count;

    // a small key pool makes hits, duplicates and deletes common
    logic [KEY_W-1:0] key_pool [16];

    chained_hash_table_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_position (o_position),
        .o_status   (o_status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // effective modulus after saturation
    function automatic int unsigned bucket_for(logic [KEY_W-1:0] key);
        int unsigned m;
        m = sh_count;
        if (m < 1) m = 1;
        if (m > NBKT) m = NBKT;
        return key % m;
    endfunction

    // apply one request to the shadow table and return its expected result
    function automatic t_outcome table_apply(t_request r);
        t_outcome    res;
        int unsigned b, n, p, prev, pos, steps;
        res = '0;
        b = bucket_for(r.key);
        case (r.kind)
            REQ_INSERT: begin
                n = NULL_LINK;
                if (sh_free != NULL_LINK) begin
                    n = sh_free;
                    sh_free = sh_links[n];
                end else if (sh_fresh < NND) begin
                    n = sh_fresh;
                    sh_fresh++;
                end
                if (n == NULL_LINK) begin
                    res.status = 1'b1;
                end else begin
                    sh_keys[n] = r.key;
                    sh_links[n] = sh_heads[b];
                    sh_heads[b] = n;
                end
            end
            REQ_SEARCH, REQ_DELETE: begin
                p = sh_heads[b];
                prev = NULL_LINK;
                pos = 1;
                steps = 0;
                while (p != NULL_LINK && steps < NND && res.position == 0) begin
                    if (sh_keys[p] == r.key) begin
                        res.position = POS_W'(pos);
                        if (r.kind == REQ_DELETE) begin
                            if (prev != NULL_LINK) sh_links[prev] = sh_links[p];
                            else sh_heads[b] = sh_links[p];
                            sh_links[p] = sh_free;
                            sh_free = p;
                        end
                    end else begin
                        prev = p;
                        p = sh_links[p];
                        pos++;
                        steps++;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // driver: new request when the current one was taken or none is up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_reqs.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                t_request r;
                r = pending_reqs.pop_front();
                expected_outcomes.push_back(table_apply(r));
                i_valid <= 1'b1;
                i_req_type <= r.kind;
                i_key <= r.key;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result with nothing expected: position %0d status %0d",
                           o_position, o_status);
                    error_count++;
                end else begin
                    t_outcome e;
                    e = expected_outcomes.pop_front();
                    if (o_position !== e.position) begin
                        $error("position: expected %0d, actual %0d", e.position,
                               o_position);
                        error_count++;
                    end
                    if (o_status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, o_status);
                        error_count++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // wait until every queued request is sent and answered
    task automatic drain();
        while (pending_reqs.size() > 0 || expected_outcomes.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        sh_count = 32'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_request pick_request();
        t_request r;
        int       sel;
        sel = $urandom_range(99);
        if (sel < 40) r.kind = REQ_INSERT;
        else if (sel < 68) r.kind = REQ_SEARCH;
        else if (sel < 97) r.kind = REQ_DELETE;
        else r.kind = REQ_UNKNOWN;
        if ($urandom_range(9) < 8) r.key = key_pool[$urandom_range(15)];
        else r.key = KEY_W'($urandom() & 32'h7fff_ffff);
        return r;
    endfunction

    task automatic run_phase(int items, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) pending_reqs.push_back(pick_request());
        drain();
    endtask

    task automatic refill_keys();
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom() & 32'h7fff_ffff);
    endtask

    initial begin
        t_request r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req_type = REQ_INSERT;
        i_key = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = CFG_RESET;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sh_count = 32'(CFG_RESET);
        foreach (sh_heads[i]) sh_heads[i] = NULL_LINK;
        foreach (sh_links[i]) sh_links[i] = NULL_LINK;
        foreach (sh_keys[i]) sh_keys[i] = '0;
        sh_free = NULL_LINK;
        sh_fresh = 0;
        refill_keys();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: key extremes, every request kind, duplicates, unknown kind
        pending_reqs.push_back('{REQ_SEARCH, 31'd0});
        pending_reqs.push_back('{REQ_INSERT, 31'd0});
        pending_reqs.push_back('{REQ_INSERT, 31'h7fff_ffff});
        pending_reqs.push_back('{REQ_INSERT, 31'd64});
        pending_reqs.push_back('{REQ_INSERT, 31'd0});
        pending_reqs.push_back('{REQ_SEARCH, 31'd0});
        pending_reqs.push_back('{REQ_SEARCH, 31'd64});
        pending_reqs.push_back('{REQ_SEARCH, 31'h7fff_ffff});
        pending_reqs.push_back('{REQ_UNKNOWN, 31'd64});
        pending_reqs.push_back('{REQ_DELETE, 31'd64});
        pending_reqs.push_back('{REQ_DELETE, 31'd64});
        pending_reqs.push_back('{REQ_DELETE, 31'd0});
        pending_reqs.push_back('{REQ_SEARCH, 31'd0});
        pending_reqs.push_back('{REQ_INSERT, 31'd128});
        drain();

        // bucket count of 0 acts as 1, so every key shares one chain
        write_buckets(7'd0);
        pending_reqs.push_back('{REQ_SEARCH, 31'd0});
        pending_reqs.push_back('{REQ_SEARCH, 31'd128});
        pending_reqs.push_back('{REQ_INSERT, 31'd5});
        pending_reqs.push_back('{REQ_SEARCH, 31'd5});
        drain();

        // count above the bucket total saturates
        write_buckets(7'd127);
        run_phase(150, 0, 0);

        // fill the pool under a tiny modulus, inserts past the pool are dropped
        write_buckets(7'd1);
        repeat (270) begin
            r.kind = REQ_INSERT;
            r.key = key_pool[$urandom_range(15)];
            pending_reqs.push_back(r);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        run_phase(200, 80, 0);

        write_buckets(7'd64);
        refill_keys();
        run_phase(250, 0, 80);
        write_buckets(7'd7);
        run_phase(250, 35, 35);
        write_buckets(7'd2);
        refill_keys();
        run_phase(250, 0, 0);
        write_buckets(7'd33);
        run_phase(250, 80, 80);

        if (error_count == 0) $display("chained_hash_table_core test passed");
        else $display("chained_hash_table_core test failed");
        $finish;
    end

    // watchdog
    initial begin
        #100ms;
        $display("chained_hash_table_core test failed");
        $finish;
    end

endmodule
